[design/button_keystroke_autorepeat_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the button keystroke autorepeat unit
// Concurrent checks, dropped from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BUTTON_KEYSTROKE_AUTOREPEAT_UNIT_ASSERT_SVH
`define BUTTON_KEYSTROKE_AUTOREPEAT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// explicit clock and active-low reset
`define BKA_ASSERT_CLK_RST(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// house clock and reset
`define BKA_ASSERT(lbl, prop, msg) \
	`BKA_ASSERT_CLK_RST(lbl, clk, arst_n, prop, msg)

`else

`define BKA_ASSERT_CLK_RST(lbl, clk_sig, rst_n_sig, prop, msg)
`define BKA_ASSERT(lbl, prop, msg)

`endif

`endif

[design/bka_pkg.sv]
// ----------------------------------------------------------------------------
// bka_pkg
// Types and constants of the button keystroke autorepeat unit.
// ----------------------------------------------------------------------------
package bka_pkg;

	localparam int NUM_BUTTONS = 14;
	localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);
	localparam int CNT_W       = 6;
	localparam int USER_W      = 2;
	localparam int KIND_W      = 2;

	localparam logic [CNT_W-1:0] RESET_REPEAT_PERIOD = CNT_W'(5);
	localparam logic [CNT_W-1:0] RESET_RELEASE_DELAY = CNT_W'(5 * 4);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_DOWN   = 2'd1,
		PH_REPEAT = 2'd2,
		PH_UP     = 2'd3
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DOWN   = 2'd0,
		KIND_REPEAT = 2'd1,
		KIND_UP     = 2'd2
	} kind_t;

	typedef enum logic [0:0] {
		REG_REPEAT_PERIOD = 1'b0,
		REG_RELEASE_DELAY = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_FINISH = 2'd2
	} state_t;

endpackage

[design/bka_if.sv]
// ----------------------------------------------------------------------------
// bka_if
// Valid/ready channels: poll words in, keystroke words out.
// ----------------------------------------------------------------------------
interface bka_in_if;
	logic                            valid;
	logic                            ready;
	logic [bka_pkg::NUM_BUTTONS-1:0] buttons_pressed;
	logic [bka_pkg::USER_W-1:0]      user_index;

	modport source (output valid, output buttons_pressed, output user_index, input ready);
	modport sink   (input valid, input buttons_pressed, input user_index, output ready);
endinterface

interface bka_out_if;
	logic                          valid;
	logic                          ready;
	logic                          event_valid;
	logic [bka_pkg::BTN_IDX_W-1:0] button_index;
	logic [bka_pkg::KIND_W-1:0]    event_kind;
	logic [bka_pkg::USER_W-1:0]    user_echo;

	modport source (output valid, output event_valid, output button_index,
		output event_kind, output user_echo, input ready);
	modport sink   (input valid, input event_valid, input button_index,
		input event_kind, input user_echo, output ready);
endinterface

[design/button_keystroke_autorepeat_unit.sv]
// ----------------------------------------------------------------------------
// button_keystroke_autorepeat_unit
// Typematic key-down / repeat / key-up events from polled button bits.
// ----------------------------------------------------------------------------
//  channel     dir  word
//  poll        in   buttons_pressed, user_index
//  keystroke   out  event_valid, button_index, event_kind, user_echo
//  cfg_*       in   register write (index, 6-bit data)
//
//  A poll is accepted, then the scan visits the buttons in turn through
//  one shared step unit over the button state (up to 14 buttons), and the
//  result is then moved into the output register.
//  Reset leaves every button idle with a zero counter; no clearing pass.
//  A stalled output holds the finished poll; the next poll is taken once the
//  output register is free again.
// ----------------------------------------------------------------------------
`include "button_keystroke_autorepeat_unit_assert.svh"

module button_keystroke_autorepeat_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	bka_in_if.sink                      poll,
	bka_out_if.source                   keystroke,
	input  logic                        cfg_wr_en,
	input  logic [0:0]                  cfg_index,
	input  logic [bka_pkg::CNT_W-1:0]   cfg_data
);

	localparam logic [bka_pkg::BTN_IDX_W-1:0] LAST_IDX =
		bka_pkg::BTN_IDX_W'(bka_pkg::NUM_BUTTONS - 1);

	bka_pkg::state_t                 state_q, state_d;
	logic [bka_pkg::CNT_W-1:0]       repeat_period_q, release_delay_q;

	bka_pkg::phase_t                 phase_q [bka_pkg::NUM_BUTTONS];
	logic [bka_pkg::CNT_W-1:0]       count_q [bka_pkg::NUM_BUTTONS];

	logic [bka_pkg::NUM_BUTTONS-1:0] pressed_q;
	logic [bka_pkg::USER_W-1:0]      user_q;
	logic [bka_pkg::BTN_IDX_W-1:0]   scan_idx_q;

	logic                            res_valid_q;
	logic [bka_pkg::BTN_IDX_W-1:0]   res_idx_q;
	bka_pkg::kind_t                  res_kind_q;

	logic                            out_valid_q;
	logic                            out_event_q;
	logic [bka_pkg::BTN_IDX_W-1:0]   out_idx_q;
	bka_pkg::kind_t                  out_kind_q;
	logic [bka_pkg::USER_W-1:0]      out_user_q;

	logic                            poll_accept, out_load, scan_end;

	// step unit
	logic                            held, cnt_zero, hit, stop, last;
	bka_pkg::phase_t                 ph, ph_nx;
	logic [bka_pkg::CNT_W-1:0]       cnt, cnt_nx;
	bka_pkg::kind_t                  kind;

	assign poll.ready  = (state_q == bka_pkg::ST_IDLE);
	assign poll_accept = poll.valid && poll.ready;

	always_comb begin
		held     = pressed_q[scan_idx_q];
		ph       = phase_q[scan_idx_q];
		cnt      = count_q[scan_idx_q];
		cnt_zero = (cnt == '0);
		hit      = 1'b0;
		stop     = 1'b0;
		kind     = bka_pkg::KIND_DOWN;
		ph_nx    = ph;
		cnt_nx   = cnt;
		if (held) begin
			unique case (ph)
				bka_pkg::PH_IDLE: begin
					ph_nx = bka_pkg::PH_DOWN;
					hit   = 1'b1;
					stop  = 1'b1;
				end
				bka_pkg::PH_DOWN, bka_pkg::PH_REPEAT: begin
					if (cnt_zero) begin
						cnt_nx = repeat_period_q;
						ph_nx  = bka_pkg::PH_REPEAT;
						kind   = bka_pkg::KIND_REPEAT;
						hit    = 1'b1;
						stop   = 1'b1;
					end else begin
						cnt_nx = cnt - 1'b1;
					end
				end
				bka_pkg::PH_UP: begin
					// held while up: wait
				end
				default: begin
				end
			endcase
		end else begin
			unique case (ph)
				bka_pkg::PH_DOWN, bka_pkg::PH_REPEAT: begin
					cnt_nx = release_delay_q;
					ph_nx  = bka_pkg::PH_UP;
					kind   = bka_pkg::KIND_UP;
					hit    = 1'b1;
					stop   = 1'b1;
				end
				bka_pkg::PH_UP: begin
					// silent clear
					ph_nx = bka_pkg::PH_IDLE;
					stop  = 1'b1;
				end
				bka_pkg::PH_IDLE: begin
				end
				default: begin
				end
			endcase
		end
		last = (scan_idx_q == LAST_IDX);
	end

	assign scan_end = stop || last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bka_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			bka_pkg::ST_IDLE: begin
				if (poll_accept) begin
					state_d = bka_pkg::ST_SCAN;
				end
			end
			bka_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = bka_pkg::ST_FINISH;
				end
			end
			bka_pkg::ST_FINISH: begin
				if (!out_valid_q || keystroke.ready) begin
					out_load = 1'b1;
					state_d  = bka_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bka_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_period_q <= bka_pkg::RESET_REPEAT_PERIOD;
			release_delay_q <= bka_pkg::RESET_RELEASE_DELAY;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bka_pkg::REG_REPEAT_PERIOD: repeat_period_q <= cfg_data;
				bka_pkg::REG_RELEASE_DELAY: release_delay_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bka_pkg::NUM_BUTTONS; i++) begin
				phase_q[i] <= bka_pkg::PH_IDLE;
				count_q[i] <= '0;
			end
		end else if (state_q == bka_pkg::ST_SCAN) begin
			phase_q[scan_idx_q] <= ph_nx;
			count_q[scan_idx_q] <= cnt_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else if (poll_accept) begin
			scan_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else if (state_q == bka_pkg::ST_SCAN) begin
			if (!scan_end) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (hit) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll_accept) begin
			pressed_q  <= poll.buttons_pressed;
			user_q     <= poll.user_index;
			res_idx_q  <= '0;
			res_kind_q <= bka_pkg::KIND_DOWN;
		end else if (state_q == bka_pkg::ST_SCAN && hit) begin
			res_idx_q  <= scan_idx_q;
			res_kind_q <= kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (keystroke.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_event_q <= res_valid_q;
			out_idx_q   <= res_idx_q;
			out_kind_q  <= res_kind_q;
			out_user_q  <= user_q;
		end
	end

	assign keystroke.valid        = out_valid_q;
	assign keystroke.event_valid  = out_event_q;
	assign keystroke.button_index = out_idx_q;
	assign keystroke.event_kind   = out_kind_q;
	assign keystroke.user_echo    = out_user_q;

	`BKA_ASSERT(a_accept_starts_scan, poll_accept |=> (state_q == bka_pkg::ST_SCAN) && (scan_idx_q == '0), "poll accepted but scan did not start at button zero")
	`BKA_ASSERT(a_scan_idx_range, (state_q == bka_pkg::ST_SCAN) |-> (scan_idx_q <= LAST_IDX), "scan index past last button")
	`BKA_ASSERT(a_no_event_zero, (keystroke.valid && !keystroke.event_valid) |-> ((keystroke.button_index == '0) && (keystroke.event_kind == bka_pkg::KIND_DOWN)), "empty keystroke word carries non-zero index or kind")
	`BKA_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> $past(state_q == bka_pkg::ST_FINISH), "output word raised outside finish state")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for button_keystroke_autorepeat_unit
// Polls are queued by an initial block and driven in bursts. Each accepted
// poll runs through a model of the typematic scan kept here, and each
// keystroke word that comes out is checked against the oldest prediction.
// The run steps the repeat period and release delay through several
// settings, including both extremes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 500;
	localparam int TAIL_CYCLES    = 24;

	typedef struct packed {
		logic [bka_pkg::NUM_BUTTONS-1:0] pressed;
		logic [bka_pkg::USER_W-1:0]      user;
	} poll_word_t;

	typedef struct packed {
		logic                          event_valid;
		logic [bka_pkg::BTN_IDX_W-1:0] button_index;
		logic [bka_pkg::KIND_W-1:0]    event_kind;
		logic [bka_pkg::USER_W-1:0]    user_echo;
	} keystroke_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [0:0]                cfg_index;
	logic [bka_pkg::CNT_W-1:0] cfg_data;

	bka_in_if  poll_ch ();
	bka_out_if key_ch ();

	button_keystroke_autorepeat_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_ch),
		.keystroke (key_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// scan model state
	bka_pkg::phase_t           btn_phase [bka_pkg::NUM_BUTTONS];
	logic [bka_pkg::CNT_W-1:0] btn_count [bka_pkg::NUM_BUTTONS];
	logic [bka_pkg::CNT_W-1:0] repeat_period = bka_pkg::RESET_REPEAT_PERIOD;
	logic [bka_pkg::CNT_W-1:0] release_delay = bka_pkg::RESET_RELEASE_DELAY;

	poll_word_t pending_polls [$];
	keystroke_t expected_keystrokes [$];

	logic       poll_taken = 1'b0;
	int         errors = 0;
	int         polls_taken_cnt = 0;
	int         down_cnt = 0;
	int         repeat_cnt = 0;
	int         up_cnt = 0;
	int         quiet_cnt = 0;
	int         settings_cnt = 1;
	int         idle_cycles = 0;
	keystroke_t seen_word;
	keystroke_t want_word;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic keystroke_t scan_poll(logic [bka_pkg::NUM_BUTTONS-1:0] pressed,
		logic [bka_pkg::USER_W-1:0] user);
		keystroke_t k;
		bit         done;
		k = '0;
		k.user_echo = user;
		done = 1'b0;
		for (int i = 0; i < bka_pkg::NUM_BUTTONS; i++) begin
			if (!done) begin
				if (pressed[i]) begin
					case (btn_phase[i])
						bka_pkg::PH_IDLE: begin
							btn_phase[i] = bka_pkg::PH_DOWN;
							k.event_valid = 1'b1;
							k.button_index = bka_pkg::BTN_IDX_W'(i);
							k.event_kind = bka_pkg::KIND_DOWN;
							done = 1'b1;
						end
						bka_pkg::PH_DOWN, bka_pkg::PH_REPEAT: begin
							if (btn_count[i] == '0) begin
								btn_count[i] = repeat_period;
								btn_phase[i] = bka_pkg::PH_REPEAT;
								k.event_valid = 1'b1;
								k.button_index = bka_pkg::BTN_IDX_W'(i);
								k.event_kind = bka_pkg::KIND_REPEAT;
								done = 1'b1;
							end else begin
								btn_count[i] = btn_count[i] - 1'b1;
							end
						end
						default: ; // held while up: wait
					endcase
				end else begin
					case (btn_phase[i])
						bka_pkg::PH_DOWN, bka_pkg::PH_REPEAT: begin
							btn_count[i] = release_delay;
							btn_phase[i] = bka_pkg::PH_UP;
							k.event_valid = 1'b1;
							k.button_index = bka_pkg::BTN_IDX_W'(i);
							k.event_kind = bka_pkg::KIND_UP;
							done = 1'b1;
						end
						bka_pkg::PH_UP: begin
							btn_phase[i] = bka_pkg::PH_IDLE;
							done = 1'b1;
						end
						default: ;
					endcase
				end
			end
		end
		return k;
	endfunction

	function automatic void check_field(string name, logic [3:0] want, logic [3:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			errors++;
		end
	endfunction

	// poll driver: bursts of words with random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	poll_word_t  next_poll;

	always @(negedge clk) begin
		if (arst_n && (!poll_ch.valid || poll_taken)) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				poll_ch.valid <= 1'b0;
			end else if (pending_polls.size() != 0) begin
				next_poll = pending_polls.pop_front();
				poll_ch.valid <= 1'b1;
				poll_ch.buttons_pressed <= next_poll.pressed;
				poll_ch.user_index <= next_poll.user;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left = burst_left - 1;
				end
			end else begin
				poll_ch.valid <= 1'b0;
			end
		end
	end

	// keystroke receiver: ready follows a duty pattern re-chosen every so often
	int unsigned rdy_period = 1;
	int unsigned rdy_duty = 1;
	int unsigned rdy_phase = 0;
	int unsigned rdy_span = 0;

	always @(negedge clk) begin
		if (rdy_span == 0) begin
			rdy_span = $urandom_range(40, 120);
			rdy_period = $urandom_range(1, 8);
			rdy_duty = ($urandom_range(0, 3) == 0) ? rdy_period : $urandom_range(1, rdy_period);
			rdy_phase = 0;
		end else begin
			rdy_span = rdy_span - 1;
		end
		key_ch.ready <= (rdy_phase < rdy_duty);
		rdy_phase = (rdy_phase + 1 >= rdy_period) ? 0 : rdy_phase + 1;
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			poll_taken <= poll_ch.valid && poll_ch.ready;
			if (poll_ch.valid && poll_ch.ready) begin
				expected_keystrokes.push_back(scan_poll(poll_ch.buttons_pressed,
					poll_ch.user_index));
				polls_taken_cnt++;
			end
			if (key_ch.valid && key_ch.ready) begin
				seen_word = '{key_ch.event_valid, key_ch.button_index,
					key_ch.event_kind, key_ch.user_echo};
				if (expected_keystrokes.size() == 0) begin
					$error("keystroke word with nothing expected");
					errors++;
				end else begin
					want_word = expected_keystrokes.pop_front();
					check_field("event_valid", 4'(want_word.event_valid),
						4'(seen_word.event_valid));
					check_field("button_index", 4'(want_word.button_index),
						4'(seen_word.button_index));
					check_field("event_kind", 4'(want_word.event_kind),
						4'(seen_word.event_kind));
					check_field("user_echo", 4'(want_word.user_echo),
						4'(seen_word.user_echo));
				end
				if (!seen_word.event_valid)
					quiet_cnt++;
				else
					case (bka_pkg::kind_t'(seen_word.event_kind))
						bka_pkg::KIND_DOWN:   down_cnt++;
						bka_pkg::KIND_REPEAT: repeat_cnt++;
						bka_pkg::KIND_UP:     up_cnt++;
						default:              ;
					endcase
			end
			if ((pending_polls.size() != 0 || poll_ch.valid || expected_keystrokes.size() != 0)
				&& !(poll_ch.valid && poll_ch.ready) && !(key_ch.valid && key_ch.ready))
				idle_cycles++;
			else
				idle_cycles = 0;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic push_poll(logic [bka_pkg::NUM_BUTTONS-1:0] pressed,
		logic [bka_pkg::USER_W-1:0] user);
		pending_polls.push_back('{pressed, user});
	endtask

	task automatic write_reg(bka_pkg::reg_idx_t idx, logic [bka_pkg::CNT_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == bka_pkg::REG_REPEAT_PERIOD)
			repeat_period = value;
		else
			release_delay = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain_polls();
		while (pending_polls.size() != 0 || poll_ch.valid || expected_keystrokes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// mostly held masks that change a few bits per poll, with some noise
	task automatic push_random(int n);
		logic [bka_pkg::NUM_BUTTONS-1:0] mask;
		int unsigned                     pick;
		mask = '0;
		for (int j = 0; j < n; j++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				repeat ($urandom_range(0, 2))
					mask[$urandom_range(0, bka_pkg::NUM_BUTTONS - 1)] ^= 1'b1;
			end else if (pick == 7) begin
				mask = bka_pkg::NUM_BUTTONS'($urandom);
			end else if (pick == 8) begin
				mask = '0;
			end else begin
				mask = '1;
			end
			push_poll(mask, bka_pkg::USER_W'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		logic [bka_pkg::CNT_W-1:0] rp;
		logic [bka_pkg::CNT_W-1:0] rd;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		poll_ch.valid = 1'b0;
		poll_ch.buttons_pressed = '0;
		poll_ch.user_index = '0;
		key_ch.ready = 1'b0;
		for (int i = 0; i < bka_pkg::NUM_BUTTONS; i++) begin
			btn_phase[i] = bka_pkg::PH_IDLE;
			btn_count[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset settings
		push_poll(14'h0000, 2'd0);
		push_poll(14'h0001, 2'd1);
		push_poll(14'h0001, 2'd2);
		push_poll(14'h0001, 2'd3);
		push_poll(14'h0000, 2'd0);
		push_poll(14'h0001, 2'd1); // held while up
		push_poll(14'h0000, 2'd2); // silent clear
		push_poll(14'h0001, 2'd3);
		push_poll(14'h0003, 2'd0);
		push_poll(14'h2000, 2'd3);
		push_poll(14'h2000, 2'd3);
		push_poll(14'h2000, 2'd1);
		push_poll(14'h2000, 2'd2);
		repeat (4) push_poll(14'h3FFF, 2'd3);
		repeat (4) push_poll(14'h0000, 2'd0);
		push_poll(14'h2AAA, 2'd1);
		push_poll(14'h1555, 2'd2);
		push_poll(14'h3FFF, 2'd3);
		push_poll(14'h0000, 2'd0);
		drain_polls();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin rp = '0; rd = '0; end
				1: begin rp = '1; rd = '1; end
				2: begin rp = '0; rd = '1; end
				3: begin rp = '1; rd = '0; end
				4: begin rp = 6'd1; rd = 6'd2; end
				default: begin
					rp = bka_pkg::CNT_W'($urandom);
					rd = bka_pkg::CNT_W'($urandom);
				end
			endcase
			write_reg(bka_pkg::REG_REPEAT_PERIOD, rp);
			write_reg(bka_pkg::REG_RELEASE_DELAY, rd);
			settings_cnt++;
			push_random(105);
			drain_polls();
		end

		if (expected_keystrokes.size() != 0) begin
			$error("%0d keystroke words never arrived", expected_keystrokes.size());
			errors++;
		end
		$display("%0d polls over %0d register settings; events seen: %0d key-down,",
			polls_taken_cnt, settings_cnt, down_cnt);
		$display("%0d repeat, %0d key-up, %0d polls with no event", repeat_cnt, up_cnt,
			quiet_cnt);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
